// ===== rtl/core/dqmb_pkg.sv =====
// shared types and constants for the dns query message builder
// no dependencies; imported by the core and its checker

package dqmb_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 4;

  localparam logic [7:0]      DotChar    = 8'h2E;
  localparam logic [CntW-1:0] HdrLast    = CntW'(11);
  localparam logic [CntW-1:0] TrlLast    = CntW'(4);
  localparam logic [15:0]     FlagsReset = 16'h0100;
  localparam logic [15:0]     QtypeReset = 16'h0001;
  localparam logic [15:0]     QclsReset  = 16'h0001;

  // header byte positions
  localparam logic [CntW-1:0] HdrIdHi    = CntW'(0);
  localparam logic [CntW-1:0] HdrIdLo    = CntW'(1);
  localparam logic [CntW-1:0] HdrFlagsHi = CntW'(2);
  localparam logic [CntW-1:0] HdrFlagsLo = CntW'(3);
  localparam logic [CntW-1:0] HdrQdLo    = CntW'(5);

  // trailer byte positions
  localparam logic [CntW-1:0] TrlRoot    = CntW'(0);
  localparam logic [CntW-1:0] TrlTypeHi  = CntW'(1);
  localparam logic [CntW-1:0] TrlTypeLo  = CntW'(2);
  localparam logic [CntW-1:0] TrlClsHi   = CntW'(3);
  localparam logic [CntW-1:0] TrlClsLo   = CntW'(4);

  typedef enum logic [1:0] {
    REG_FLAGS = 2'd0,
    REG_QTYPE = 2'd1,
    REG_QCLS  = 2'd2
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_HDR   = 5'b00010,
    ST_LEN   = 5'b00100,
    ST_CHARS = 5'b01000,
    ST_TRL   = 5'b10000
  } state_e;

endpackage

// ===== rtl/core/dns_query_message_builder_core.sv =====
// dns query message builder core: header, label encoding and trailer sequencer
// depends on dqmb_pkg; label characters sit in a local synchronous memory

// Takes a dotted domain name one character per item and sends out the dns
// query message one byte per item in wire order. The item that opens a
// message puts out the 12-byte header first (id from that item, flags
// register, question count 1, three zero counts), which holds off input
// until the header has gone out. An ordinary character is written into the
// label memory. A dot, or end_of_name, that closes a nonempty label puts out
// the length byte and then reads the label back from the memory, one byte
// per cycle while the output is not stalled; the end adds the root zero
// byte, qtype and qclass, and message_last marks the final byte. Each
// character is buffered in the label memory on input and read back from it
// for sending, through its single write port and single read port.
// Input is taken only while the sequencer is idle. Labels longer than
// LABEL_MAX drop their extra characters and the length byte saturates with
// label_overflow set. The memory needs no clearing: only entries below the
// fill count are ever read, and each label entry is written before its first
// read, so no forwarding path is needed.

module dns_query_message_builder_core #(
  parameter int unsigned LABEL_MAX = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // name characters
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  name_char_i,
  input  logic                        end_of_name_i,
  input  logic [15:0]                 query_id_i,
  // message bytes
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_byte_o,
  output logic                        message_last_o,
  output logic                        label_overflow_o,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dqmb_pkg::AddrW-1:0]  paddr,
  input  logic [dqmb_pkg::DataW-1:0]  pwdata,
  output logic [dqmb_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import dqmb_pkg::*;

  localparam int unsigned FillW = $clog2(LABEL_MAX + 1);
  localparam int unsigned IdxW  = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam logic [FillW-1:0] FillMax = FillW'(LABEL_MAX);

  // configuration registers
  logic [15:0] flags_q, qtype_q, qcls_q;
  logic        cfg_we;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= FlagsReset;
      qtype_q <= QtypeReset;
      qcls_q  <= QclsReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FLAGS: flags_q <= pwdata[15:0];
        REG_QTYPE: qtype_q <= pwdata[15:0];
        REG_QCLS:  qcls_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FLAGS: prdata = {16'h0000, flags_q};
      REG_QTYPE: prdata = {16'h0000, qtype_q};
      REG_QCLS:  prdata = {16'h0000, qcls_q};
      default:   prdata = '0;
    endcase
  end

  // sequencer state
  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             ovf_q, ovf_d;
  logic             in_msg_q, in_msg_d;
  logic             end_q, end_d;
  logic [15:0]      id_q;

  // output register
  logic       ovalid_q, ovalid_d;
  logic [7:0] obyte_q, obyte_d;
  logic       olast_q, olast_d;
  logic       oovf_q, oovf_d;

  // label memory
  logic [7:0]      mem_q [LABEL_MAX];
  logic [7:0]      rdata_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;

  logic             accept, adv, first, nonempty;
  logic [FillW-1:0] eff_fill;
  logic             eff_ovf;
  logic             emit;
  logic [7:0]       ebyte;
  logic             elast, eovf;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign adv        = !ovalid_q || out_ready_i;
  assign first      = !in_msg_q;
  assign eff_fill   = first ? '0 : fill_q;
  assign eff_ovf    = first ? 1'b0 : ovf_q;
  assign nonempty   = (eff_fill != '0) || eff_ovf;

  assign mem_waddr  = eff_fill[IdxW-1:0];
  assign mem_we     = accept && !end_of_name_i && (name_char_i != DotChar)
                      && (eff_fill < FillMax);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= name_char_i;
    end
    rdata_q <= mem_q[idx_d];
  end

  always_ff @(posedge clk_i) begin
    if (accept && first) begin
      id_q <= query_id_i;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    fill_d   = fill_q;
    ovf_d    = ovf_q;
    in_msg_d = in_msg_q;
    end_d    = end_q;
    emit     = 1'b0;
    ebyte    = 8'h00;
    elast    = 1'b0;
    eovf     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          end_d    = end_of_name_i;
          in_msg_d = !end_of_name_i;
          fill_d   = eff_fill;
          ovf_d    = eff_ovf;
          cnt_d    = '0;
          idx_d    = '0;
          if (!end_of_name_i && name_char_i != DotChar) begin
            if (eff_fill < FillMax) begin
              fill_d = eff_fill + FillW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (first) begin
            state_d = ST_HDR;
          end else if (end_of_name_i || name_char_i == DotChar) begin
            if (nonempty) begin
              state_d = ST_LEN;
            end else if (end_of_name_i) begin
              state_d = ST_TRL;
            end
          end
        end
      end

      ST_HDR: begin
        emit = 1'b1;
        case (cnt_q)
          HdrIdHi:    ebyte = id_q[15:8];
          HdrIdLo:    ebyte = id_q[7:0];
          HdrFlagsHi: ebyte = flags_q[15:8];
          HdrFlagsLo: ebyte = flags_q[7:0];
          HdrQdLo:    ebyte = 8'h01;
          default:    ebyte = 8'h00;
        endcase
        if (adv) begin
          cnt_d = cnt_q + CntW'(1);
          if (cnt_q == HdrLast) begin
            // label holds only the opening item's character, if any, right after the header
            cnt_d   = '0;
            state_d = end_q ? ST_TRL : ST_IDLE;
          end
        end
      end

      ST_LEN: begin
        emit  = 1'b1;
        ebyte = 8'(fill_q);
        eovf  = ovf_q;
        if (adv) begin
          idx_d   = '0;
          state_d = ST_CHARS;
        end
      end

      ST_CHARS: begin
        emit  = 1'b1;
        ebyte = rdata_q;
        if (adv) begin
          if (FillW'(idx_q) + FillW'(1) == fill_q) begin
            fill_d  = '0;
            ovf_d   = 1'b0;
            cnt_d   = '0;
            state_d = end_q ? ST_TRL : ST_IDLE;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end

      ST_TRL: begin
        emit = 1'b1;
        case (cnt_q)
          TrlRoot:   ebyte = 8'h00;
          TrlTypeHi: ebyte = qtype_q[15:8];
          TrlTypeLo: ebyte = qtype_q[7:0];
          TrlClsHi:  ebyte = qcls_q[15:8];
          TrlClsLo:  ebyte = qcls_q[7:0];
          default:   ebyte = 8'h00;
        endcase
        elast = (cnt_q == TrlLast);
        if (adv) begin
          cnt_d = cnt_q + CntW'(1);
          if (cnt_q == TrlLast) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // output register loads whenever the slot is free or being drained
  always_comb begin
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    oovf_d   = oovf_q;
    if (adv) begin
      ovalid_d = emit;
      obyte_d  = ebyte;
      olast_d  = elast;
      oovf_d   = eovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      fill_q   <= '0;
      ovf_q    <= 1'b0;
      in_msg_q <= 1'b0;
      end_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      fill_q   <= fill_d;
      ovf_q    <= ovf_d;
      in_msg_q <= in_msg_d;
      end_q    <= end_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    oovf_q  <= oovf_d;
  end

  assign out_valid_o      = ovalid_q;
  assign out_byte_o       = obyte_q;
  assign message_last_o   = olast_q;
  assign label_overflow_o = oovf_q;

endmodule

// ===== rtl/core/dqmb_checker.sv =====
// port-level checks for the dns query message builder core
// depends on dqmb_pkg; bound to dns_query_message_builder_core below

module dqmb_checker #(
  parameter int unsigned LABEL_MAX = 32
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        end_of_name_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [7:0]                  out_byte_o,
  input logic                        message_last_o,
  input logic                        label_overflow_o,
  input logic [dqmb_pkg::DataW-1:0]  prdata,
  input logic                        pready
);
  import dqmb_pkg::*;

  // a stalled byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(message_last_o) && $stable(label_overflow_o))
    else $error("output byte changed while stalled");

  // overflow only on a saturated length byte
  a_ovf_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && label_overflow_o |-> out_byte_o == 8'(LABEL_MAX) && !message_last_o)
    else $error("label overflow on a byte that is not a saturated length");

  // an end item always produces a trailer, so input closes right after it
  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && end_of_name_i |=> !in_ready_o)
    else $error("input still open after end of name");

  // register port never waits and reads back only 16 bits
  a_apb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready && prdata[DataW-1:16] == '0)
    else $error("register port misbehaves");

endmodule

bind dns_query_message_builder_core dqmb_checker #(.LABEL_MAX(LABEL_MAX)) u_dqmb_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .end_of_name_i    (end_of_name_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .out_byte_o       (out_byte_o),
  .message_last_o   (message_last_o),
  .label_overflow_o (label_overflow_o),
  .prdata           (prdata),
  .pready           (pready)
);
